[rtl/asu_pkg.sv]
// Shared types and codes for the ARM shifter-operand unit.
// No dependencies; imported by arm_shifter_operand_unit.
`default_nettype none

package asu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam logic [7:0] WORD_BITS = 8'd32;

  // action codes
  localparam logic [1:0] ACT_SHIFT     = 2'b00;
  localparam logic [1:0] ACT_IMM_SHIFT = 2'b01;
  localparam logic [1:0] ACT_THUMB     = 2'b10;

  // explicit shift type codes
  localparam logic [2:0] SH_LSL = 3'd0;
  localparam logic [2:0] SH_LSR = 3'd1;
  localparam logic [2:0] SH_ASR = 3'd2;
  localparam logic [2:0] SH_ROR = 3'd3;
  localparam logic [2:0] SH_RRX = 3'd4;

  // thumb replicated-byte patterns
  localparam logic [1:0] PAT_BYTE = 2'b00;
  localparam logic [1:0] PAT_HALF = 2'b01;
  localparam logic [1:0] PAT_ODD  = 2'b10;
  localparam logic [1:0] PAT_ALL  = 2'b11;

  // where the carry comes from once the rotate is done
  typedef enum logic [1:0] {
    CS_FIXED,
    CS_BIT0,
    CS_BIT31
  } csel_t;

  // decoded operation carried down the pipe
  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic [4:0]        rot;
    logic [WORD_W-1:0] keep;
    logic              fill;
    csel_t             csel;
    logic              cfix;
  } op_t;

endpackage

`default_nettype wire

[rtl/arm_shifter_operand_unit.sv]
// ARM shifter-operand unit: explicit shift, immediate-encoded shift and
// Thumb modified-immediate expansion in a three-stage pipeline.
// Depends on asu_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one request per beat: action,
//   operand, shift_type, shift_amount, imm_field, c_flag. Output channel
//   out_valid/out_ready carries one result beat per request: valid_res,
//   result, shift_carry, in request order.
//   Throughput: one beat per cycle unless the receiver stalls. Stage 1
//   decodes the request into a rotate amount, keep mask, fill bit and
//   carry source; stage 2 rotates by the coarse part of the amount
//   (multiples of 4); stage 3 rotates by the fine part, merges mask and
//   fill and picks the carry.
//   Every stage holds its own valid bit and advances when the stage after
//   it is empty or moving, so bubbles are squeezed out and a stalled
//   receiver backs the pipe up without losing or repeating a beat;
//   in_ready drops only once all three stages are full.
//   Reset (rst, synchronous, active high) empties all stages.
`default_nettype none

module arm_shifter_operand_unit
  import asu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [WORD_W-1:0] operand,
  input  wire logic [2:0]        shift_type,
  input  wire logic [7:0]        shift_amount,
  input  wire logic [11:0]       imm_field,
  input  wire logic              c_flag,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   valid_res,
  output logic [WORD_W-1:0]      result,
  output logic                   shift_carry
);

  // pipeline occupancy and advance enables
  logic s1_vld, s2_vld;
  logic adv1, adv2, adv3;
  op_t  dec, s1, s2;

  assign adv3     = !out_valid || out_ready;
  assign adv2     = !s2_vld || adv3;
  assign adv1     = !s1_vld || adv2;
  assign in_ready = adv1;

  // ---------------------------------------------------------------------
  // Stage 1 decode: every case is reduced to "rotate data right by rot,
  // keep the bits in keep, fill the rest with fill, take carry per csel".
  // Pass-through and constant outcomes use rot 0, full keep, fixed carry.
  // LSL by n is a right rotate by 32-n with carry from bit 0; LSR, ASR and
  // ROR rotate right by n with carry from bit 31.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [2:0] typ;
    logic [7:0] amt;
    logic [7:0] tb;
    logic       sign;

    typ  = shift_type;
    amt  = shift_amount;
    tb   = imm_field[7:0];
    sign = operand[WORD_W-1];

    dec.ok   = 1'b1;
    dec.data = operand;
    dec.rot  = 5'd0;
    dec.keep = ALL_ONES;
    dec.fill = 1'b0;
    dec.csel = CS_FIXED;
    dec.cfix = c_flag;

    // immediate-encoded form: imm5 of 0 means 32 for LSR/ASR, RRX for ROR
    if (action == ACT_IMM_SHIFT) begin
      amt = {3'b000, imm_field[4:0]};
      typ = {1'b0, shift_type[1:0]};
      if (imm_field[4:0] == 5'd0) begin
        case (typ)
          SH_LSR, SH_ASR: amt = WORD_BITS;
          SH_ROR: begin
            typ = SH_RRX;
            amt = 8'd1;
          end
          default: amt = 8'd0;
        endcase
      end
    end

    case (action)
      ACT_SHIFT, ACT_IMM_SHIFT: begin
        if (typ == SH_RRX) begin
          if (amt != 8'd1) begin
            dec.ok   = 1'b0;
            dec.data = '0;
            dec.cfix = 1'b0;
          end else begin
            dec.data = {c_flag, operand[WORD_W-1:1]};
            dec.cfix = operand[0];
          end
        end else if (typ > SH_RRX) begin
          dec.ok   = 1'b0;
          dec.data = '0;
          dec.cfix = 1'b0;
        end else if (amt != 8'd0) begin
          case (typ)
            SH_LSL: begin
              if (amt > WORD_BITS) begin
                dec.data = '0;
                dec.cfix = 1'b0;
              end else begin
                dec.rot  = 5'(~amt[4:0] + 5'd1);
                dec.keep = (amt == WORD_BITS) ? '0 : (ALL_ONES << amt[4:0]);
                dec.csel = CS_BIT0;
              end
            end
            SH_LSR: begin
              if (amt > WORD_BITS) begin
                dec.data = '0;
                dec.cfix = 1'b0;
              end else begin
                dec.rot  = amt[4:0];
                dec.keep = (amt == WORD_BITS) ? '0 : (ALL_ONES >> amt[4:0]);
                dec.csel = CS_BIT31;
              end
            end
            SH_ASR: begin
              if (amt >= WORD_BITS) begin
                dec.data = {WORD_W{sign}};
                dec.cfix = sign;
              end else begin
                dec.rot  = amt[4:0];
                dec.keep = ALL_ONES >> amt[4:0];
                dec.fill = sign;
                dec.csel = CS_BIT31;
              end
            end
            default: begin
              // ROR; a nonzero multiple of 32 leaves data, carry is bit 31
              dec.rot  = amt[4:0];
              dec.csel = CS_BIT31;
            end
          endcase
        end
      end
      ACT_THUMB: begin
        if (imm_field[11:10] == 2'b00) begin
          case (imm_field[9:8])
            PAT_BYTE: dec.data = {24'd0, tb};
            PAT_HALF: dec.data = {8'd0, tb, 8'd0, tb};
            PAT_ODD:  dec.data = {tb, 8'd0, tb, 8'd0};
            PAT_ALL:  dec.data = {tb, tb, tb, tb};
            default:  dec.data = {24'd0, tb};
          endcase
          // replicated patterns of a zero byte are unpredictable encodings
          if (imm_field[9:8] != PAT_BYTE && tb == 8'd0) begin
            dec.ok   = 1'b0;
            dec.data = '0;
            dec.cfix = 1'b0;
          end
        end else begin
          dec.data = {24'd0, 1'b1, imm_field[6:0]};
          dec.rot  = imm_field[11:7];
          dec.csel = CS_BIT31;
        end
      end
      default: begin
        dec.ok   = 1'b0;
        dec.data = '0;
        dec.cfix = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv1) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1 <= dec;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: coarse rotate by rot[4:2] * 4
  // ---------------------------------------------------------------------
  logic [2*WORD_W-1:0] coarse;
  op_t                 s2_next;

  always_comb begin
    coarse       = {s1.data, s1.data} >> {s1.rot[4:2], 2'b00};
    s2_next      = s1;
    s2_next.data = coarse[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv2) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_vld) begin
      s2 <= s2_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: fine rotate by rot[1:0], merge mask and fill, pick carry
  // ---------------------------------------------------------------------
  logic [2*WORD_W-1:0] fine;
  logic [WORD_W-1:0]   rotated;
  logic [WORD_W-1:0]   result_next;
  logic                carry_next;

  always_comb begin
    fine        = {s2.data, s2.data} >> s2.rot[1:0];
    rotated     = fine[WORD_W-1:0];
    result_next = (rotated & s2.keep) | ({WORD_W{s2.fill}} & ~s2.keep);
    case (s2.csel)
      CS_BIT0:  carry_next = rotated[0];
      CS_BIT31: carry_next = rotated[WORD_W-1];
      default:  carry_next = s2.cfix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_vld) begin
      valid_res   <= s2.ok;
      result      <= result_next;
      shift_carry <= carry_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a rejected request never leaks a value or a carry
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> result == '0 && !shift_carry)
    else $error("invalid result beat carries nonzero payload");

  // decode of a rejected request is a fixed zero with no rotate
  a_dec_invalid: assert property (@(posedge clk) disable iff (rst)
    s1_vld && !s1.ok |-> s1.data == '0 && !s1.cfix && s1.csel == CS_FIXED)
    else $error("invalid request decoded to nonzero operation");

  // input is open whenever the first stage is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_vld |-> in_ready)
    else $error("in_ready low with empty first stage");

  // a stalled output with stage 2 full keeps stage 2 and the output stage occupied
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s2_vld |=> out_valid && s2_vld)
    else $error("stalled pipeline dropped a beat");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for arm_shifter_operand_unit: directed corner beats, then random
// beats with bursty input and a stalling receiver. Every result beat is checked in order.
// Depends on asu_pkg and arm_shifter_operand_unit from rtl/.

module tb_top;
  import asu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves unnamed: the reserved action and the unused explicit types.
  localparam logic [1:0] ACT_RESERVED = 2'b11;
  localparam logic [2:0] SH_UNDEF_LO  = 3'd5;
  localparam logic [2:0] SH_UNDEF_HI  = 3'd7;

  localparam int unsigned RANDOM_BEATS = 600;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_PRINTS   = 40;

  typedef struct {
    logic [1:0]        action;
    logic [WORD_W-1:0] operand;
    logic [2:0]        shift_type;
    logic [7:0]        shift_amount;
    logic [11:0]       imm_field;
    logic              c_flag;
  } shift_req_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] val;
    logic              cy;
  } operand_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = ACT_SHIFT;
  logic [WORD_W-1:0] operand = '0;
  logic [2:0]        shift_type = SH_LSL;
  logic [7:0]        shift_amount = '0;
  logic [11:0]       imm_field = '0;
  logic              c_flag = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              valid_res;
  logic [WORD_W-1:0] result;
  logic              shift_carry;

  shift_req_t   request_q[$];    // beats waiting to be driven
  operand_res_t predicted_q[$];  // results owed by the unit, oldest first

  int unsigned mismatches = 0;
  int unsigned result_beats = 0;
  int unsigned cycles = 0;
  bit          in_taken = 1'b0;  // input beat accepted at the last rising edge

  arm_shifter_operand_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .operand      (operand),
    .shift_type   (shift_type),
    .shift_amount (shift_amount),
    .imm_field    (imm_field),
    .c_flag       (c_flag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_res    (valid_res),
    .result       (result),
    .shift_carry  (shift_carry)
  );

  // ---------------------------------------------------------------------------
  // Predictor. A malformed request yields ok low with value and carry forced to 0.
  // ---------------------------------------------------------------------------
  function automatic operand_res_t make_res(logic ok, logic [WORD_W-1:0] v, logic c);
    operand_res_t r;
    r.ok  = ok;
    r.val = ok ? v : '0;
    r.cy  = ok ? c : 1'b0;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rotate_right(logic [WORD_W-1:0] x, int unsigned n);
    int unsigned k;
    k = n % WORD_W;
    if (k == 0) return x;
    return (x >> k) | (x << (WORD_W - k));
  endfunction

  // Amount is an int unsigned, so both the explicit 8-bit amount and the encoded 32 fit.
  function automatic operand_res_t barrel_shift(logic [WORD_W-1:0] x, logic [2:0] ty,
                                                int unsigned amt, logic cin);
    logic              sign;
    logic [WORD_W-1:0] v;
    sign = x[WORD_W-1];
    if (ty > SH_RRX) return make_res(1'b0, '0, 1'b0);
    if (ty == SH_RRX) begin
      if (amt != 1) return make_res(1'b0, '0, 1'b0);
      return make_res(1'b1, {cin, x[WORD_W-1:1]}, x[0]);
    end
    // zero amount: operand and carry pass straight through
    if (amt == 0) return make_res(1'b1, x, cin);
    case (ty)
      SH_LSL: begin
        if (amt > WORD_W) return make_res(1'b1, '0, 1'b0);
        if (amt == WORD_W) return make_res(1'b1, '0, x[0]);
        return make_res(1'b1, x << amt, x[WORD_W - amt]);
      end
      SH_LSR: begin
        if (amt > WORD_W) return make_res(1'b1, '0, 1'b0);
        if (amt == WORD_W) return make_res(1'b1, '0, sign);
        return make_res(1'b1, x >> amt, x[amt - 1]);
      end
      SH_ASR: begin
        // 32 or more: all sign bits, carry is the sign
        if (amt >= WORD_W) return make_res(1'b1, {WORD_W{sign}}, sign);
        v = $unsigned($signed(x) >>> amt);
        return make_res(1'b1, v, x[amt - 1]);
      end
      default: begin
        // ROR: a nonzero multiple of 32 leaves x, carry still comes from bit 31
        v = rotate_right(x, amt);
        return make_res(1'b1, v, v[WORD_W-1]);
      end
    endcase
  endfunction

  function automatic operand_res_t expand_thumb_imm(logic [11:0] imm, logic cin);
    logic [7:0]        b;
    logic [WORD_W-1:0] v;
    b = imm[7:0];
    if (imm[11:10] == 2'b00) begin
      if (imm[9:8] == PAT_BYTE) return make_res(1'b1, {24'b0, b}, cin);
      // replicated forms of a zero byte are malformed
      if (b == 8'h00) return make_res(1'b0, '0, 1'b0);
      case (imm[9:8])
        PAT_HALF: v = {8'b0, b, 8'b0, b};
        PAT_ODD:  v = {b, 8'b0, b, 8'b0};
        default:  v = {b, b, b, b};
      endcase
      return make_res(1'b1, v, cin);
    end
    // rotated form: 1:imm[6:0] rotated right by imm[11:7], carry is the top bit
    v = rotate_right({24'b0, 1'b1, imm[6:0]}, 32'(imm[11:7]));
    return make_res(1'b1, v, v[WORD_W-1]);
  endfunction

  function automatic operand_res_t predict_operand(shift_req_t q);
    logic [2:0]  ty;
    int unsigned imm5;
    case (q.action)
      ACT_SHIFT:
        return barrel_shift(q.operand, q.shift_type, 32'(q.shift_amount), q.c_flag);
      ACT_IMM_SHIFT: begin
        // bit 2 of the type and the explicit amount are don't-cares here
        ty   = {1'b0, q.shift_type[1:0]};
        imm5 = 32'(q.imm_field[4:0]);
        if (imm5 == 0) begin
          if (ty == SH_ROR) return barrel_shift(q.operand, SH_RRX, 1, q.c_flag);
          if (ty == SH_LSR || ty == SH_ASR)
            return barrel_shift(q.operand, ty, WORD_W, q.c_flag);
        end
        return barrel_shift(q.operand, ty, imm5, q.c_flag);
      end
      ACT_THUMB:
        return expand_thumb_imm(q.imm_field, q.c_flag);
      default:
        return make_res(1'b0, '0, 1'b0);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(logic [1:0] act, logic [WORD_W-1:0] op, logic [2:0] ty,
                         logic [7:0] amt, logic [11:0] imm, logic cin);
    shift_req_t q;
    q.action       = act;
    q.operand      = op;
    q.shift_type   = ty;
    q.shift_amount = amt;
    q.imm_field    = imm;
    q.c_flag       = cin;
    request_q.push_back(q);
  endtask

  // Operands lean toward the values that expose sign and edge-bit handling.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return {1'b1, {(WORD_W-1){1'b0}}};
      3:       return {{(WORD_W-1){1'b0}}, 1'b1};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_amount();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(30, 34));
      2:       return 8'(32 * $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 33));
    endcase
  endfunction

  task automatic add_random_req();
    logic [1:0]  act;
    logic [2:0]  ty;
    logic [7:0]  amt;
    logic [11:0] imm;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    ty   = 3'($urandom_range(0, 7));
    amt  = 8'($urandom_range(0, 255));
    imm  = 12'($urandom_range(0, 4095));
    if (pick < 40) begin
      act = ACT_SHIFT;
      // mostly legal types; the undefined ones still show up now and then
      if ($urandom_range(0, 9) != 0) ty = 3'($urandom_range(SH_LSL, SH_RRX));
      amt = pick_amount();
      if (ty == SH_RRX && $urandom_range(0, 4) != 0) amt = 8'd1;
    end else if (pick < 70) begin
      act = ACT_IMM_SHIFT;
      if ($urandom_range(0, 4) == 0) imm[4:0] = 5'd0;
    end else if (pick < 95) begin
      act = ACT_THUMB;
      if ($urandom_range(0, 1) == 0) begin
        imm[11:10] = 2'b00;
        if ($urandom_range(0, 4) == 0) imm[7:0] = 8'h00;
      end
    end else begin
      act = ACT_RESERVED;
    end
    add_req(act, pick_word(), ty, amt, imm, 1'($urandom_range(0, 1)));
  endtask

  task automatic load_directed();
    // shift corners: zero amount, exactly 32, past 32, big amounts
    add_req(ACT_SHIFT, 32'h8000_0001, SH_LSL, 8'd0,   12'h000, 1'b1);
    add_req(ACT_SHIFT, 32'h0000_0001, SH_LSL, 8'd32,  12'h000, 1'b0);
    add_req(ACT_SHIFT, ALL_ONES,      SH_LSL, 8'd33,  12'h000, 1'b1);
    add_req(ACT_SHIFT, 32'h8000_0000, SH_LSR, 8'd32,  12'h000, 1'b0);
    add_req(ACT_SHIFT, ALL_ONES,      SH_LSR, 8'd255, 12'h000, 1'b1);
    add_req(ACT_SHIFT, 32'h8000_0000, SH_ASR, 8'd32,  12'h000, 1'b0);
    add_req(ACT_SHIFT, 32'h8000_F000, SH_ASR, 8'd200, 12'h000, 1'b0);
    add_req(ACT_SHIFT, 32'h8000_0010, SH_ASR, 8'd5,   12'h000, 1'b1);
    add_req(ACT_SHIFT, 32'h1234_5678, SH_ROR, 8'd64,  12'h000, 1'b0);
    add_req(ACT_SHIFT, 32'h8765_4321, SH_ROR, 8'd200, 12'h000, 1'b0);
    // RRX only legal with amount 1; undefined explicit types are rejected
    add_req(ACT_SHIFT, 32'h0000_0003, SH_RRX, 8'd1,   12'h000, 1'b1);
    add_req(ACT_SHIFT, 32'h0000_0003, SH_RRX, 8'd0,   12'h000, 1'b1);
    add_req(ACT_SHIFT, ALL_ONES,      SH_UNDEF_LO, 8'd1, 12'h000, 1'b1);
    // encoded shifts: imm5 of zero means 32 (LSR/ASR) or RRX (ROR)
    add_req(ACT_IMM_SHIFT, 32'hC000_0001, SH_LSL, 8'hFF, 12'hFE0, 1'b1);
    add_req(ACT_IMM_SHIFT, 32'hC000_0001, SH_LSR, 8'h00, 12'h000, 1'b0);
    add_req(ACT_IMM_SHIFT, 32'h8000_0000, SH_ASR, 8'h00, 12'h000, 1'b0);
    add_req(ACT_IMM_SHIFT, 32'h0000_0001, SH_ROR, 8'h00, 12'h000, 1'b1);
    // bit 2 of the type ignored, so this decodes as ROR by 13
    add_req(ACT_IMM_SHIFT, 32'hDEAD_BEEF, SH_UNDEF_HI, 8'hFF, 12'h00D, 1'b0);
    // thumb expansion: plain byte, zero byte forms, replications, rotations
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'h0AB, 1'b1);
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'h000, 1'b1);
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'h100, 1'b1);
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'h2FF, 1'b0);
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'h3A5, 1'b1);
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'h400, 1'b0);
    add_req(ACT_THUMB, '0, SH_LSL, 8'd0, 12'hFFF, 1'b0);
    add_req(ACT_RESERVED, ALL_ONES, SH_LSL, 8'd1, 12'hFFF, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    load_directed();
    repeat (RANDOM_BEATS) add_random_req();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // all beats handed over, then all results back, then a quiet tail to catch extras;
    // polled at the rising edge, where the driver's values have settled
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results seen", cycles, result_beats);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: bursts of back-to-back beats separated by random gaps.
  // Changes at the falling edge; a beat is held until the edge that takes it.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    shift_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        q = request_q.pop_front();
        action       <= q.action;
        operand      <= q.operand;
        shift_type   <= q.shift_type;
        shift_amount <= q.shift_amount;
        imm_field    <= q.imm_field;
        c_flag       <= q.c_flag;
        in_valid     <= 1'b1;
        burst_left--;
        // a quarter of the bursts run straight into the next one
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a mode picked per stretch of cycles -
  // always ready, coin flip, mostly stalled, or a fixed on/off pattern.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_phase[2];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, predict any input beat taken and check any
  // result beat taken against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("Mismatch at result beat %0d, %s: got %h, expected %h",
               result_beats, what, got, want);
  endtask

  always @(posedge clk) begin
    shift_req_t   q;
    operand_res_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        q.action       = action;
        q.operand      = operand;
        q.shift_type   = shift_type;
        q.shift_amount = shift_amount;
        q.imm_field    = imm_field;
        q.c_flag       = c_flag;
        predicted_q.push_back(predict_operand(q));
      end
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("beat with nothing outstanding", result, '0);
        end else begin
          want = predicted_q.pop_front();
          if (valid_res !== want.ok)
            report_mismatch("valid_res", WORD_W'(valid_res), WORD_W'(want.ok));
          if (result !== want.val) report_mismatch("result", result, want.val);
          if (shift_carry !== want.cy)
            report_mismatch("shift_carry", WORD_W'(shift_carry), WORD_W'(want.cy));
        end
        result_beats++;
      end
    end
  end

endmodule

[filelist.f]
rtl/asu_pkg.sv
rtl/arm_shifter_operand_unit.sv
verif/tb_top.sv
